// ===== src/assert_macros.svh =====
// Assertion helpers. Empty under synthesis.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS
`define CLA_ASSERT_CLK(lbl, clk, rstn, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (prop)) \
    else $error("assertion failed");
`define CLA_ASSERT(lbl, prop) `CLA_ASSERT_CLK(lbl, clk_i, rst_ni, prop)
`else
`define CLA_ASSERT_CLK(lbl, clk, rstn, prop)
`define CLA_ASSERT(lbl, prop)
`endif

`endif

// ===== src/cla_pkg.sv =====
package cla_pkg;

  localparam int unsigned LINE_DEPTH = 32;
  localparam int unsigned IDX_W      = $clog2(LINE_DEPTH);
  localparam int unsigned LEN_W      = 6;
  localparam int unsigned BYTE_W     = 8;

  localparam logic [BYTE_W-1:0] CH_LF = 8'h0A;
  localparam logic [BYTE_W-1:0] CH_CR = 8'h0D;
  localparam logic [BYTE_W-1:0] CH_BS = 8'h08;
  localparam logic [BYTE_W-1:0] CH_SP = 8'h20;

  typedef enum logic [1:0] {
    KIND_ECHO = 2'd0,
    KIND_LINE = 2'd1,
    KIND_END  = 2'd2,
    KIND_OVF  = 2'd3
  } kind_e;

  typedef enum logic [2:0] {
    SRC_BYTE,
    SRC_SP,
    SRC_BS,
    SRC_LINE,
    SRC_END,
    SRC_OVF
  } src_e;

  typedef struct packed {
    logic latch_byte;
    logic emit;
    src_e emit_sel;
    logic emit_last;
    logic store_we;
    logic fill_inc;
    logic fill_dec;
    logic fill_clr;
    logic rd_start;
    logic rd_en;
    logic rd_inc;
  } cmd_t;

  typedef struct packed {
    logic is_lf;
    logic is_bs;
    logic echo_en;
    logic fill_zero;
    logic fill_last;
    logic rd_at_end;
    logic out_free;
  } sts_t;

endpackage

// ===== src/cla_rx_if.sv =====
interface cla_rx_if;
  logic                         valid;
  logic                         ready;
  logic [cla_pkg::BYTE_W-1:0]   rx_byte;

  modport source (output valid, output rx_byte, input ready);
  modport sink   (input valid, input rx_byte, output ready);
endinterface

// ===== src/cla_res_if.sv =====
interface cla_res_if;
  logic                         valid;
  logic                         ready;
  logic [1:0]                   kind;
  logic [cla_pkg::BYTE_W-1:0]   data;
  logic [cla_pkg::LEN_W-1:0]    line_length;
  logic                         last;

  modport source (output valid, output kind, output data, output line_length,
                  output last, input ready);
  modport sink   (input valid, input kind, input data, input line_length,
                  input last, output ready);
endinterface

// ===== src/cla_ctrl.sv =====
module cla_ctrl (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          rx_valid_i,
  output logic          rx_ready_o,
  input  cla_pkg::sts_t sts_i,
  output cla_pkg::cmd_t cmd_o
);

  typedef enum logic [8:0] {
    ST_IDLE    = 9'b000000001,
    ST_ECHO    = 9'b000000010,
    ST_ECHO_SP = 9'b000000100,
    ST_ECHO_BS = 9'b000001000,
    ST_ACT     = 9'b000010000,
    ST_LINE_RD = 9'b000100000,
    ST_LINE_EM = 9'b001000000,
    ST_END     = 9'b010000000,
    ST_OVF     = 9'b100000000
  } state_e;

  state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d    = state_q;
    rx_ready_o = 1'b0;
    cmd_o      = '0;
    cmd_o.emit_sel = cla_pkg::SRC_BYTE;
    unique case (state_q)
      ST_IDLE: begin
        rx_ready_o = 1'b1;
        if (rx_valid_i) begin
          cmd_o.latch_byte = 1'b1;
          state_d = sts_i.echo_en ? ST_ECHO : ST_ACT;
        end
      end
      ST_ECHO: begin
        cmd_o.emit_sel  = cla_pkg::SRC_BYTE;
        cmd_o.emit_last = !sts_i.is_lf && !sts_i.is_bs && !sts_i.fill_last;
        if (sts_i.out_free) begin
          cmd_o.emit = 1'b1;
          state_d = sts_i.is_bs ? ST_ECHO_SP : ST_ACT;
        end
      end
      ST_ECHO_SP: begin
        cmd_o.emit_sel = cla_pkg::SRC_SP;
        if (sts_i.out_free) begin
          cmd_o.emit = 1'b1;
          state_d = ST_ECHO_BS;
        end
      end
      ST_ECHO_BS: begin
        cmd_o.emit_sel  = cla_pkg::SRC_BS;
        cmd_o.emit_last = 1'b1;
        if (sts_i.out_free) begin
          cmd_o.emit = 1'b1;
          state_d = ST_ACT;
        end
      end
      ST_ACT: begin
        if (sts_i.is_lf) begin
          cmd_o.rd_start = 1'b1;
          state_d = sts_i.fill_zero ? ST_END : ST_LINE_RD;
        end else if (sts_i.is_bs) begin
          cmd_o.fill_dec = !sts_i.fill_zero;
          state_d = ST_IDLE;
        end else begin
          cmd_o.store_we = 1'b1;
          if (sts_i.fill_last) begin
            cmd_o.fill_clr = 1'b1;
            state_d = ST_OVF;
          end else begin
            cmd_o.fill_inc = 1'b1;
            state_d = ST_IDLE;
          end
        end
      end
      ST_LINE_RD: begin
        cmd_o.rd_en = 1'b1;
        state_d = ST_LINE_EM;
      end
      ST_LINE_EM: begin
        cmd_o.emit_sel = cla_pkg::SRC_LINE;
        if (sts_i.out_free) begin
          cmd_o.emit   = 1'b1;
          cmd_o.rd_inc = 1'b1;
          state_d = sts_i.rd_at_end ? ST_END : ST_LINE_RD;
        end
      end
      ST_END: begin
        cmd_o.emit_sel  = cla_pkg::SRC_END;
        cmd_o.emit_last = 1'b1;
        if (sts_i.out_free) begin
          cmd_o.emit     = 1'b1;
          cmd_o.fill_clr = 1'b1;
          state_d = ST_IDLE;
        end
      end
      ST_OVF: begin
        cmd_o.emit_sel  = cla_pkg::SRC_OVF;
        cmd_o.emit_last = 1'b1;
        if (sts_i.out_free) begin
          cmd_o.emit = 1'b1;
          state_d = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

endmodule

// ===== src/cla_dpath.sv =====
`include "assert_macros.svh"

module cla_dpath (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       cfg_we_i,
  input  logic                       cfg_wdata_i,
  input  logic [cla_pkg::BYTE_W-1:0] rx_byte_i,
  input  cla_pkg::cmd_t              cmd_i,
  output cla_pkg::sts_t              sts_o,
  cla_res_if.source                  res_o
);

  logic                       echo_q;
  logic [cla_pkg::BYTE_W-1:0] byte_q;
  logic [cla_pkg::IDX_W-1:0]  fill_q, fill_d;
  logic [cla_pkg::IDX_W-1:0]  rd_idx_q;
  logic [cla_pkg::BYTE_W-1:0] store_q [cla_pkg::LINE_DEPTH];
  logic [cla_pkg::BYTE_W-1:0] rdata_q;

  logic                       out_valid_q;
  cla_pkg::kind_e             out_kind_q, kind_d;
  logic [cla_pkg::BYTE_W-1:0] out_data_q, data_d;
  logic [cla_pkg::LEN_W-1:0]  out_len_q, len_d;
  logic                       out_last_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      echo_q <= 1'b1;
    end else if (cfg_we_i) begin
      echo_q <= cfg_wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.latch_byte) begin
      byte_q <= rx_byte_i;
    end
  end

  always_comb begin
    fill_d = fill_q;
    if (cmd_i.fill_clr) begin
      fill_d = '0;
    end else if (cmd_i.fill_inc) begin
      fill_d = fill_q + cla_pkg::IDX_W'(1);
    end else if (cmd_i.fill_dec) begin
      fill_d = fill_q - cla_pkg::IDX_W'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fill_q   <= '0;
      rd_idx_q <= '0;
    end else begin
      fill_q <= fill_d;
      if (cmd_i.rd_start) begin
        rd_idx_q <= '0;
      end else if (cmd_i.rd_inc) begin
        rd_idx_q <= rd_idx_q + cla_pkg::IDX_W'(1);
      end
    end
  end

  // line store: one write port, one registered read port
  always_ff @(posedge clk_i) begin
    if (cmd_i.store_we) begin
      store_q[fill_q] <= byte_q;
    end
    if (cmd_i.rd_en) begin
      rdata_q <= store_q[rd_idx_q];
    end
  end

  assign sts_o.is_lf     = (byte_q == cla_pkg::CH_LF);
  assign sts_o.is_bs     = (byte_q == cla_pkg::CH_BS);
  assign sts_o.echo_en   = echo_q;
  assign sts_o.fill_zero = (fill_q == '0);
  assign sts_o.fill_last = (fill_q == cla_pkg::IDX_W'(cla_pkg::LINE_DEPTH - 1));
  assign sts_o.rd_at_end = ((rd_idx_q + cla_pkg::IDX_W'(1)) == fill_q);
  assign sts_o.out_free  = !out_valid_q || res_o.ready;

  always_comb begin
    kind_d = cla_pkg::KIND_ECHO;
    data_d = byte_q;
    len_d  = '0;
    case (cmd_i.emit_sel)
      cla_pkg::SRC_BYTE: data_d = byte_q;
      cla_pkg::SRC_SP:   data_d = cla_pkg::CH_SP;
      cla_pkg::SRC_BS:   data_d = cla_pkg::CH_BS;
      cla_pkg::SRC_LINE: begin
        kind_d = cla_pkg::KIND_LINE;
        // trailing CR goes out as zero
        data_d = (sts_o.rd_at_end && rdata_q == cla_pkg::CH_CR) ? '0 : rdata_q;
      end
      cla_pkg::SRC_END: begin
        kind_d = cla_pkg::KIND_END;
        data_d = '0;
        len_d  = cla_pkg::LEN_W'(fill_q);
      end
      cla_pkg::SRC_OVF: begin
        kind_d = cla_pkg::KIND_OVF;
        data_d = '0;
      end
      default: data_d = byte_q;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.emit) begin
      out_valid_q <= 1'b1;
    end else if (res_o.ready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.emit) begin
      out_kind_q <= kind_d;
      out_data_q <= data_d;
      out_len_q  <= len_d;
      out_last_q <= cmd_i.emit_last;
    end
  end

  assign res_o.valid       = out_valid_q;
  assign res_o.kind        = out_kind_q;
  assign res_o.data        = out_data_q;
  assign res_o.line_length = out_len_q;
  assign res_o.last        = out_last_q;

  `CLA_ASSERT(a_emit_slot_free, cmd_i.emit |-> sts_o.out_free)
  `CLA_ASSERT(a_fill_in_range, fill_q <= cla_pkg::IDX_W'(cla_pkg::LINE_DEPTH - 1))
  `CLA_ASSERT(a_dec_not_empty, cmd_i.fill_dec |-> fill_q != '0)
  `CLA_ASSERT(a_read_below_fill, cmd_i.rd_en |-> rd_idx_q < fill_q)

endmodule

// ===== src/console_line_assembler_unit.sv =====
// Console line assembler. Takes one received byte per rx beat and keeps a
// LINE_DEPTH-byte line store, which holds no defined contents after reset and
// needs no clearing. With echo on, each byte is echoed, and a backspace is
// echoed as backspace, space, backspace. A line feed sends out the stored
// bytes (a trailing CR as zero) and then a line-end beat with the length. A
// byte that fills the store empties it and adds an overflow beat. The last
// beat of each input byte carries last. On a line feed the controller walks
// the store through its registered read port, reading each stored byte and
// then emitting it. A new byte is taken while the last result still waits in
// the output register.
module console_line_assembler_unit (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      cfg_we_i,
  input  logic      cfg_wdata_i,
  cla_rx_if.sink    rx_i,
  cla_res_if.source res_o
);

  cla_pkg::cmd_t cmd;
  cla_pkg::sts_t sts;

  cla_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .rx_valid_i (rx_i.valid),
    .rx_ready_o (rx_i.ready),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  cla_dpath u_dpath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .rx_byte_i   (rx_i.rx_byte),
    .cmd_i       (cmd),
    .sts_o       (sts),
    .res_o       (res_o)
  );

endmodule

// ===== dv/tb_top.sv =====
module tb_top;
  import cla_pkg::*;

  localparam int RANDOM_ITEMS  = 320;
  localparam int SETTLE_CYCLES = 80;
  localparam int HOLD_CYCLES   = 400;
  localparam int CALM_LEN      = 80;
  localparam int QUIET_LIMIT   = 3000;
  localparam int IDLE_PCT      = 23;

  typedef enum logic [0:0] {
    ROW_BYTE,
    ROW_ECHO
  } row_e;

  typedef struct packed {
    kind_e             kind;
    logic [BYTE_W-1:0] data;
    logic [LEN_W-1:0]  len;
    logic              last;
  } res_beat_t;

  typedef struct {
    row_e              op;
    logic [BYTE_W-1:0] val;
    int                reps;
    bit                typed;
    kind_e             t_kind;
    logic [BYTE_W-1:0] t_data;
    logic [LEN_W-1:0]  t_len;
  } plan_row_t;

  logic clk_i;
  logic rst_ni;
  logic cfg_we_i;
  logic cfg_wdata_i;

  cla_rx_if  rx_if();
  cla_res_if res_if();

  console_line_assembler_unit u_dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .rx_i        (rx_if),
    .res_o       (res_if)
  );

  // predictor state
  logic [BYTE_W-1:0] line_copy [LINE_DEPTH];
  int unsigned       line_fill;
  bit                echo_on;

  res_beat_t   awaited_beats[$];
  res_beat_t   want_beat;
  plan_row_t   opening_plan [24];
  int          mismatches;
  int          bytes_sent;
  int          calm_from;
  int          hold_at;
  int          hold_left;
  int          quiet_cycles;
  bit          no_idle;
  bit          hold_request;
  bit          hold_done;

  initial clk_i = 1'b0;
  always #5 clk_i = ~clk_i;

  function automatic void push_beat(kind_e k, logic [BYTE_W-1:0] d, logic [LEN_W-1:0] l);
    res_beat_t r;
    r.kind = k;
    r.data = d;
    r.len  = l;
    r.last = 1'b0;
    awaited_beats.push_back(r);
  endfunction

  function automatic void predict_console_beats(logic [BYTE_W-1:0] b);
    int                start;
    logic [BYTE_W-1:0] d;
    start = awaited_beats.size();
    if (line_fill >= LINE_DEPTH) line_fill = 0;
    if (echo_on) begin
      push_beat(KIND_ECHO, b, '0);
      if (b == CH_BS) begin
        push_beat(KIND_ECHO, CH_SP, '0);
        push_beat(KIND_ECHO, CH_BS, '0);
      end
    end
    if (b == CH_LF) begin
      for (int unsigned i = 0; i < line_fill; i++) begin
        d = line_copy[i];
        if (i + 1 == line_fill && d == CH_CR) d = '0;
        push_beat(KIND_LINE, d, '0);
      end
      push_beat(KIND_END, '0, LEN_W'(line_fill));
      line_fill = 0;
    end else if (b == CH_BS) begin
      if (line_fill > 0) line_fill--;
    end else begin
      line_copy[line_fill] = b;
      line_fill++;
      if (line_fill >= LINE_DEPTH) begin
        line_fill = 0;
        push_beat(KIND_OVF, '0, '0);
      end
    end
    if (awaited_beats.size() > start) awaited_beats[$].last = 1'b1;
  endfunction

  task automatic flag_mismatch(string field, logic [BYTE_W-1:0] got, logic [BYTE_W-1:0] exp_v);
    $display("mismatch on %s: got %0h, expected %0h", field, got, exp_v);
    mismatches++;
  endtask

  task automatic send_beat(logic [BYTE_W-1:0] b, bit typed, res_beat_t want);
    int start;
    no_idle = (bytes_sent >= calm_from) && (bytes_sent < calm_from + CALM_LEN);
    if (!hold_done && bytes_sent >= hold_at) begin
      hold_request = 1'b1;
      hold_done    = 1'b1;
    end
    while (!no_idle && $urandom_range(0, 99) < IDLE_PCT) begin
      rx_if.valid <= 1'b0;
      @(posedge clk_i);
    end
    rx_if.valid   <= 1'b1;
    rx_if.rx_byte <= b;
    do @(posedge clk_i); while (!rx_if.ready);
    start = awaited_beats.size();
    predict_console_beats(b);
    if (typed) begin
      while (awaited_beats.size() > start) void'(awaited_beats.pop_back());
      awaited_beats.push_back(want);
    end
    bytes_sent++;
  endtask

  task automatic wait_drained();
    rx_if.valid <= 1'b0;
    while (awaited_beats.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  task automatic write_echo(bit v);
    wait_drained();
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= v;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    echo_on = v;
  endtask

  // result checker
  always @(posedge clk_i) begin
    if (rst_ni && res_if.valid && res_if.ready) begin
      if (awaited_beats.size() == 0) begin
        flag_mismatch("unexpected beat, data", res_if.data, '0);
      end else begin
        want_beat = awaited_beats.pop_front();
        if (res_if.kind !== want_beat.kind)
          flag_mismatch("kind", BYTE_W'(res_if.kind), BYTE_W'(want_beat.kind));
        if (res_if.data !== want_beat.data) flag_mismatch("data", res_if.data, want_beat.data);
        if (res_if.line_length !== want_beat.len)
          flag_mismatch("line_length", BYTE_W'(res_if.line_length), BYTE_W'(want_beat.len));
        if (res_if.last !== want_beat.last)
          flag_mismatch("last", BYTE_W'(res_if.last), BYTE_W'(want_beat.last));
      end
    end
  end

  always @(posedge clk_i) begin
    if ((rx_if.valid && rx_if.ready) || (res_if.valid && res_if.ready)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
    if (quiet_cycles >= QUIET_LIMIT) begin
      $display("tb_top failed");
      $finish;
    end
  end

  // result side: random stalls plus one long hold-off
  initial begin
    res_if.ready = 1'b0;
    forever begin
      @(posedge clk_i);
      if (hold_left != 0) begin
        hold_left--;
        res_if.ready <= 1'b0;
      end else if (hold_request) begin
        hold_request = 1'b0;
        hold_left    = HOLD_CYCLES;
        res_if.ready <= 1'b0;
      end else begin
        res_if.ready <= no_idle || ($urandom_range(0, 99) >= IDLE_PCT);
      end
    end
  end

  initial begin
    res_beat_t         row_want;
    res_beat_t         no_want;
    logic [BYTE_W-1:0] b;
    int                random_stop;
    int                phase_end;
    int                phase_no;
    int                line_len;
    int                k;

    rst_ni        = 1'b0;
    cfg_we_i      = 1'b0;
    cfg_wdata_i   = 1'b0;
    rx_if.valid   = 1'b0;
    rx_if.rx_byte = '0;
    mismatches    = 0;
    bytes_sent    = 0;
    calm_from     = 32'h7fff_ffff;
    hold_at       = 32'h7fff_ffff;
    hold_left     = 0;
    quiet_cycles  = 0;
    no_idle       = 1'b0;
    hold_request  = 1'b0;
    hold_done     = 1'b0;
    line_fill     = 0;
    echo_on       = 1'b1;
    no_want       = '0;

    opening_plan = '{
      '{ROW_BYTE, 8'h41,  1,            1'b1, KIND_ECHO, 8'h41, 6'd0},
      '{ROW_BYTE, CH_BS,  1,            1'b0, KIND_ECHO, 8'h00, 6'd0},
      '{ROW_BYTE, CH_BS,  1,            1'b0, KIND_ECHO, 8'h00, 6'd0},
      '{ROW_BYTE, 8'h00,  1,            1'b1, KIND_ECHO, 8'h00, 6'd0},
      '{ROW_BYTE, 8'hFF,  1,            1'b1, KIND_ECHO, 8'hFF, 6'd0},
      '{ROW_BYTE, CH_CR,  1,            1'b1, KIND_ECHO, CH_CR, 6'd0},
      '{ROW_BYTE, CH_LF,  1,            1'b0, KIND_ECHO, 8'h00, 6'd0},
      '{ROW_BYTE, CH_LF,  1,            1'b0, KIND_ECHO, 8'h00, 6'd0},
      '{ROW_ECHO, 8'h00,  1,            1'b0, KIND_ECHO, 8'h00, 6'd0},
      '{ROW_BYTE, CH_LF,  1,            1'b1, KIND_END,  8'h00, 6'd0},
      '{ROW_BYTE, 8'h78,  1,            1'b0, KIND_ECHO, 8'h00, 6'd0},
      '{ROW_BYTE, CH_CR,  1,            1'b0, KIND_ECHO, 8'h00, 6'd0},
      '{ROW_BYTE, 8'h79,  1,            1'b0, KIND_ECHO, 8'h00, 6'd0},
      '{ROW_BYTE, CH_BS,  1,            1'b0, KIND_ECHO, 8'h00, 6'd0},
      '{ROW_BYTE, CH_LF,  1,            1'b0, KIND_ECHO, 8'h00, 6'd0},
      '{ROW_BYTE, 8'h7E,  LINE_DEPTH-1, 1'b0, KIND_ECHO, 8'h00, 6'd0},
      '{ROW_BYTE, 8'h55,  1,            1'b1, KIND_OVF,  8'h00, 6'd0},
      '{ROW_BYTE, CH_LF,  1,            1'b1, KIND_END,  8'h00, 6'd0},
      '{ROW_ECHO, 8'h01,  1,            1'b0, KIND_ECHO, 8'h00, 6'd0},
      '{ROW_BYTE, 8'hA5,  LINE_DEPTH-1, 1'b0, KIND_ECHO, 8'h00, 6'd0},
      '{ROW_BYTE, CH_LF,  1,            1'b0, KIND_ECHO, 8'h00, 6'd0},
      '{ROW_BYTE, 8'h5A,  LINE_DEPTH-1, 1'b0, KIND_ECHO, 8'h00, 6'd0},
      '{ROW_BYTE, 8'hC3,  1,            1'b0, KIND_ECHO, 8'h00, 6'd0},
      '{ROW_BYTE, CH_SP,  1,            1'b1, KIND_ECHO, CH_SP, 6'd0}
    };

    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (opening_plan[i]) begin
      if (opening_plan[i].op == ROW_ECHO) begin
        write_echo(opening_plan[i].val[0]);
      end else begin
        row_want.kind = opening_plan[i].t_kind;
        row_want.data = opening_plan[i].t_data;
        row_want.len  = opening_plan[i].t_len;
        row_want.last = 1'b1;
        for (k = 0; k < opening_plan[i].reps; k++) begin
          send_beat(opening_plan[i].val, opening_plan[i].typed, row_want);
        end
      end
    end

    random_stop = bytes_sent + RANDOM_ITEMS;
    hold_at     = bytes_sent + 100;
    calm_from   = bytes_sent + 220;
    phase_no    = 0;
    while (bytes_sent < random_stop) begin
      phase_end = bytes_sent + $urandom_range(40, 90);
      if (phase_no < 2) write_echo(phase_no[0]);
      else write_echo(1'($urandom_range(0, 1)));
      phase_no++;
      while (bytes_sent < phase_end && bytes_sent < random_stop) begin
        if ($urandom_range(0, 4) == 0) begin
          b = BYTE_W'($urandom_range(0, 255));
          send_beat(b, 1'b0, no_want);
        end else begin
          // mostly short lines, now and then a long one that may overflow
          line_len = ($urandom_range(0, 7) == 0) ? $urandom_range(28, 40)
                                                 : $urandom_range(0, 12);
          for (k = 0; k < line_len; k++) begin
            if ($urandom_range(0, 9) == 0) begin
              b = CH_BS;
            end else if ($urandom_range(0, 3) == 0) begin
              b = BYTE_W'($urandom_range(0, 255));
              if (b == CH_LF) b = CH_CR;
            end else begin
              b = BYTE_W'($urandom_range(8'h21, 8'h7E));
            end
            send_beat(b, 1'b0, no_want);
          end
          if ($urandom_range(0, 2) == 0) send_beat(CH_CR, 1'b0, no_want);
          send_beat(CH_LF, 1'b0, no_want);
        end
      end
    end

    wait_drained();
    if (mismatches == 0) begin
      $display("tb_top passed");
    end else begin
      $display("tb_top failed");
    end
    $finish;
  end

endmodule
